[sv/morse_key_decoder_assert.svh]
// Assertion macros for the Morse key decoder.
// Included by the top level; no other dependencies.
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MKD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MKD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[sv/mkd_pkg.sv]
// Shared types, constants and the Morse letter table for the key decoder.
// No dependencies.
`timescale 1ns / 1ps

package mkd_pkg;

   localparam int MKD_MAX_SYMBOLS = 5;
   localparam int CNT_W           = 16;
   localparam int LETTER_W        = 5;
   localparam int CSR_IDX_W       = 3;
   localparam int NUM_LETTERS     = 26;
   localparam int TBL_LEN_W       = 3;
   localparam int TBL_BITS_W      = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

   // register reset values
   localparam logic [CNT_W-1:0] DOT_MIN_RESET  = 16'd500;
   localparam logic [CNT_W-1:0] DASH_MIN_RESET = 16'd1201;
   localparam logic [CNT_W-1:0] DASH_MAX_RESET = 16'd2400;
   localparam logic [CNT_W-1:0] GAP_LIMIT_RESET = 16'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT = 3'd3;

   typedef enum logic [1:0] {
      EV_DOT    = 2'd0,
      EV_DASH   = 2'd1,
      EV_LETTER = 2'd2,
      EV_ERROR  = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type       kind;
      logic [LETTER_W-1:0]  letter;
   } rsp_word_type;

   typedef struct packed {
      logic                 error;
      logic [LETTER_W-1:0]  letter;
   } decode_type;

   // a..z, symbol i in bit i, 1 = dash
   localparam logic [TBL_LEN_W-1:0] LETTER_LEN [NUM_LETTERS] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
      3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
      3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3,
      3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   localparam logic [TBL_BITS_W-1:0] LETTER_BITS [NUM_LETTERS] = '{
      4'd2,  4'd1,  4'd5,  4'd1,  4'd0,  4'd4,  4'd3,
      4'd0,  4'd0,  4'd14, 4'd5,  4'd2,  4'd3,  4'd1,
      4'd7,  4'd6,  4'd11, 4'd2,  4'd0,  4'd1,  4'd4,
      4'd8,  4'd6,  4'd9,  4'd13, 4'd3
   };

endpackage

[sv/mkd_letter_decode.sv]
// Matches collected dot/dash symbols against the a..z table.
// Depends on mkd_pkg.
`timescale 1ns / 1ps

module mkd_letter_decode #(
   parameter int MAX_SYMBOLS = mkd_pkg::MKD_MAX_SYMBOLS
) (
   input  logic [MAX_SYMBOLS-1:0]           symbol_bits,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0] symbol_length,
   input  logic                             symbol_overflow,
   output mkd_pkg::decode_type              decode
);
   import mkd_pkg::*;

   localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);

   logic                found;
   logic [LETTER_W-1:0] letter;

   // codes are unique, so the first hit is the only hit
   always_comb begin
      found  = 1'b0;
      letter = '0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (!found && symbol_length == LEN_W'(LETTER_LEN[i]) &&
             symbol_bits == MAX_SYMBOLS'(LETTER_BITS[i])) begin
            found  = 1'b1;
            letter = LETTER_W'(i);
         end
      end
   end

   always_comb begin
      decode.error  = symbol_overflow || (symbol_length == '0) || !found;
      decode.letter = decode.error ? '0 : letter;
   end

endmodule

[sv/morse_key_decoder.sv]
// Morse key decoder: one key sample per word in, dot/dash/letter/error words out.
// Result words are registered: each enters the output register, or the skid when stalled.
// Throughput: one sample per cycle while req_stall is low; the output, a register
// plus skid entry, keeps req_stall registered and raises it only after a stall.
// Reset: synchronous, clears counters and symbols, returns registers to defaults.
// Depends on mkd_pkg, mkd_letter_decode and morse_key_decoder_assert.svh.
`timescale 1ns / 1ps
`include "morse_key_decoder_assert.svh"

module morse_key_decoder #(
   parameter int MAX_SYMBOLS = mkd_pkg::MKD_MAX_SYMBOLS
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_key_pressed,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_event_kind,
   output logic [mkd_pkg::LETTER_W-1:0]      rsp_letter_index,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mkd_pkg::CNT_W-1:0]         csr_data
);
   import mkd_pkg::*;

   localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_SYMBOLS);

   // ---------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown
   // indexes are dropped.
   // ---------------------------------------------------------------
   logic [CNT_W-1:0] dot_min_ff, dash_min_ff, dash_max_ff, gap_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_min_ff   <= DOT_MIN_RESET;
         dash_min_ff  <= DASH_MIN_RESET;
         dash_max_ff  <= DASH_MAX_RESET;
         gap_limit_ff <= GAP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DOT_MIN:   dot_min_ff   <= csr_data;
            CSR_DASH_MIN:  dash_min_ff  <= csr_data;
            CSR_DASH_MAX:  dash_max_ff  <= csr_data;
            CSR_GAP_LIMIT: gap_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Decoder state
   // ---------------------------------------------------------------
   logic [CNT_W-1:0]       press_ff, press_in;
   logic [CNT_W-1:0]       gap_ff, gap_in;
   logic [MAX_SYMBOLS-1:0] sym_bits_ff, sym_bits_in;
   logic [LEN_W-1:0]       sym_len_ff, sym_len_in;
   logic                   overflow_ff, overflow_in;
   logic                   waiting_ff, waiting_in;
   logic                   key_was_ff, key_was_in;

   logic                   req_accept;
   logic                   produce;
   rsp_word_type           new_word;
   decode_type             decode;
   logic [CNT_W-1:0]       gap_inc;
   logic                   is_dot, is_dash;

   assign req_accept = req_valid && !req_stall;

   mkd_letter_decode #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) u_decode (
      .symbol_bits    (sym_bits_ff),
      .symbol_length  (sym_len_ff),
      .symbol_overflow(overflow_ff),
      .decode         (decode)
   );

   // press classification; an out-of-order window simply never matches
   assign is_dot  = (press_ff >= dot_min_ff) && (press_ff < dash_min_ff);
   assign is_dash = (press_ff >= dash_min_ff) && (press_ff <= dash_max_ff);
   assign gap_inc = (gap_ff == CNT_MAX) ? CNT_MAX : gap_ff + 1'b1;

   always_comb begin
      press_in    = press_ff;
      gap_in      = gap_ff;
      sym_bits_in = sym_bits_ff;
      sym_len_in  = sym_len_ff;
      overflow_in = overflow_ff;
      waiting_in  = waiting_ff;
      key_was_in  = key_was_ff;
      produce     = 1'b0;
      new_word.kind   = EV_DOT;
      new_word.letter = '0;

      if (req_accept) begin
         if (req_key_pressed) begin
            // key held: count the press, any gap is over
            press_in   = (press_ff == CNT_MAX) ? CNT_MAX : press_ff + 1'b1;
            gap_in     = '0;
            waiting_in = 1'b0;
            key_was_in = 1'b1;
         end else if (key_was_ff) begin
            // release edge: classify, start the gap (not counted this tick)
            key_was_in = 1'b0;
            press_in   = '0;
            gap_in     = '0;
            waiting_in = 1'b1;
            if (is_dot || is_dash) begin
               produce       = 1'b1;
               new_word.kind = is_dot ? EV_DOT : EV_DASH;
               if (sym_len_ff < LEN_FULL) begin
                  sym_bits_in = sym_bits_ff |
                                (MAX_SYMBOLS'(is_dot ? 1'b0 : 1'b1) << sym_len_ff);
                  sym_len_in  = sym_len_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end else if (waiting_ff) begin
            gap_in = gap_inc;
            if (gap_inc > gap_limit_ff) begin
               // letter boundary: report and clear the symbol register
               produce         = 1'b1;
               new_word.kind   = decode.error ? EV_ERROR : EV_LETTER;
               new_word.letter = decode.letter;
               sym_bits_in     = '0;
               sym_len_in      = '0;
               overflow_in     = 1'b0;
               gap_in          = '0;
               waiting_in      = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff    <= '0;
         gap_ff      <= '0;
         sym_bits_ff <= '0;
         sym_len_ff  <= '0;
         overflow_ff <= 1'b0;
         waiting_ff  <= 1'b0;
         key_was_ff  <= 1'b0;
      end else begin
         press_ff    <= press_in;
         gap_ff      <= gap_in;
         sym_bits_ff <= sym_bits_in;
         sym_len_ff  <= sym_len_in;
         overflow_ff <= overflow_in;
         waiting_ff  <= waiting_in;
         key_was_ff  <= key_was_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register plus skid entry. The skid fills only when a new
   // word arrives while the output word is stalled; req_stall is the
   // skid's valid bit, so it never depends on rsp_stall directly.
   // ---------------------------------------------------------------
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         rsp_take;

   assign rsp_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      priority if (skid_valid_ff) begin
         // input is stalled here, so nothing new arrives
         if (rsp_take) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp_take) begin
            skid_word_in  = new_word;
            skid_valid_in = 1'b1;
         end else begin
            out_word_in  = new_word;
            out_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end else begin
         // nothing moves: output holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_word_ff.kind;
   assign rsp_letter_index = out_word_ff.letter;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `MKD_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid word without output word")
   `MKD_ASSERT_IMPLY(a_overflow_full, clock, reset, overflow_ff, sym_len_ff == LEN_FULL, "overflow while symbol register not full")
   `MKD_ASSERT_IMPLY(a_len_bound, clock, reset, 1'b1, sym_len_ff <= LEN_FULL, "symbol length beyond capacity")
   `MKD_ASSERT_NEXT(a_press_ends_gap, clock, reset, req_accept && req_key_pressed, !waiting_ff && gap_ff == '0 && key_was_ff, "press did not close the gap")

endmodule
